/* rtl/tlb_entry_probe_write_unit_defines.svh */
// Assertion macros used by the top level of the translation buffer RTL.
`ifndef TLB_ENTRY_PROBE_WRITE_UNIT_DEFINES_SVH
`define TLB_ENTRY_PROBE_WRITE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TEPW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TEPW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tepw_pkg.sv */
// Shared types and constants of the translation buffer.
package tepw_pkg;

  localparam int OPCODE_W = 2;
  localparam int VADDR_W  = 52;
  localparam int ASID_W   = 8;
  localparam int PFN_W    = 40;
  localparam int SLOT_W   = 8;
  localparam int MSLOT_W  = 6;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PROBE = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_FLUSH = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_LOAD,
    ST_WRITE,
    ST_FLUSH,
    ST_PUSH
  } state_t;

  // Write and flush strobes toward the entry store.
  typedef struct packed {
    logic wr_en;
    logic flush;
  } st_ctl_t;

endpackage

/* rtl/tepw_match.sv */
// Entry compare unit: masked page compare plus address-space check.
module tepw_match import tepw_pkg::*; #(
  parameter int VPN_BITS = 52
) (
  input  logic [VPN_BITS-1:0] probe_vpn,
  input  logic [ASID_W-1:0]   probe_asid,
  input  logic                e_present,
  input  logic [VPN_BITS-1:0] e_vpn,
  input  logic [VPN_BITS-1:0] e_mask,
  input  logic [ASID_W-1:0]   e_asid,
  input  logic                e_global,
  output logic                hit
);

  logic vpn_eq;
  logic asid_ok;

  // Set mask bits drop out of the compare.
  assign vpn_eq  = (((probe_vpn ^ e_vpn) & ~e_mask) == '0);
  assign asid_ok = e_global || (e_asid == probe_asid);
  assign hit     = e_present && vpn_eq && asid_ok;

endmodule

/* rtl/tepw_store.sv */
// Entry store: field memories with one write and one registered read port.
module tepw_store import tepw_pkg::*; #(
  parameter int ENTRIES    = 64,
  parameter int VPN_BITS   = 52,
  parameter int FRAME_BITS = 40,
  parameter int IDX_W      = $clog2(ENTRIES)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  st_ctl_t               ctl,
  input  logic [IDX_W-1:0]      wr_addr,
  input  logic [VPN_BITS-1:0]   wr_vpn,
  input  logic [VPN_BITS-1:0]   wr_mask,
  input  logic [ASID_W-1:0]     wr_asid,
  input  logic                  wr_global,
  input  logic [FRAME_BITS-1:0] wr_frame_even,
  input  logic [FRAME_BITS-1:0] wr_frame_odd,
  input  logic                  wr_valid_even,
  input  logic                  wr_valid_odd,
  input  logic [IDX_W-1:0]      rd_addr,
  output logic                  rd_present,
  output logic [VPN_BITS-1:0]   rd_vpn,
  output logic [VPN_BITS-1:0]   rd_mask,
  output logic [ASID_W-1:0]     rd_asid,
  output logic                  rd_global,
  output logic [FRAME_BITS-1:0] rd_frame_even,
  output logic [FRAME_BITS-1:0] rd_frame_odd,
  output logic                  rd_valid_even,
  output logic                  rd_valid_odd
);

  logic [ENTRIES-1:0]    present_r;
  logic [VPN_BITS-1:0]   vpn_mem    [ENTRIES];
  logic [VPN_BITS-1:0]   mask_mem   [ENTRIES];
  logic [ASID_W-1:0]     asid_mem   [ENTRIES];
  logic                  global_mem [ENTRIES];
  logic [FRAME_BITS-1:0] fe_mem     [ENTRIES];
  logic [FRAME_BITS-1:0] fo_mem     [ENTRIES];
  logic                  ve_mem     [ENTRIES];
  logic                  vo_mem     [ENTRIES];

  // Present bits: flush drops every entry at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else if (ctl.flush) begin
      present_r <= '0;
    end else if (ctl.wr_en) begin
      present_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      vpn_mem[wr_addr]    <= wr_vpn;
      mask_mem[wr_addr]   <= wr_mask;
      asid_mem[wr_addr]   <= wr_asid;
      global_mem[wr_addr] <= wr_global;
      fe_mem[wr_addr]     <= wr_frame_even;
      fo_mem[wr_addr]     <= wr_frame_odd;
      ve_mem[wr_addr]     <= wr_valid_even;
      vo_mem[wr_addr]     <= wr_valid_odd;
    end
  end

  always_ff @(posedge clk) begin
    rd_present    <= present_r[rd_addr];
    rd_vpn        <= vpn_mem[rd_addr];
    rd_mask       <= mask_mem[rd_addr];
    rd_asid       <= asid_mem[rd_addr];
    rd_global     <= global_mem[rd_addr];
    rd_frame_even <= fe_mem[rd_addr];
    rd_frame_odd  <= fo_mem[rd_addr];
    rd_valid_even <= ve_mem[rd_addr];
    rd_valid_odd  <= vo_mem[rd_addr];
  end

endmodule

/* rtl/tlb_entry_probe_write_unit.sv */
// Top level of the fully associative translation buffer with ASID and page mask.
//
// Input channel (in_valid/in_ready): one beat carries an opcode and entry fields.
//   Probe searches all present entries for a masked page match in the given
//   address space; write stores a whole entry at in_slot; read returns the
//   entry at in_slot; flush drops every entry.
// Result channel (out_valid/out_ready): exactly one beat per input beat, in order.
//   A slot at or beyond ENTRIES on write or read gives status 1 and no effect.
// Steps from input accept to result valid:
//   probe  the scan of one entry per cycle through the single read port
//          of the entry store and one compare unit
//   read   address, registered memory read, result stage
//   write, flush  store strobe, result stage; refused write/read  result stage
// One item is in work at a time; in_ready is high only while idle, so the next
// beat can be taken once a result has entered the output register, even while
// that result still waits to be taken.
// When the receiver stalls, the finished result waits in a staging register
// and the block holds until the output register frees up.
// Reset (synchronous, rst_n low) empties the buffer and the output register;
// entry contents need no clearing pass since present bits mark written entries.
`include "tlb_entry_probe_write_unit_defines.svh"

module tlb_entry_probe_write_unit import tepw_pkg::*; #(
  parameter int ENTRIES    = 64,
  parameter int VPN_BITS   = 52,
  parameter int FRAME_BITS = 40
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [VADDR_W-1:0] in_virt_page,
  input  logic [ASID_W-1:0]  in_space_id,
  input  logic [VADDR_W-1:0] in_page_mask,
  input  logic               in_global_flag,
  input  logic [PFN_W-1:0]   in_frame_even,
  input  logic [PFN_W-1:0]   in_frame_odd,
  input  logic               in_valid_even,
  input  logic               in_valid_odd,
  input  logic [SLOT_W-1:0]  in_slot,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_status,
  output logic               out_hit,
  output logic [MSLOT_W-1:0] out_match_slot,
  output logic [PFN_W-1:0]   out_frame_even,
  output logic [PFN_W-1:0]   out_frame_odd,
  output logic               out_valid_even,
  output logic               out_valid_odd
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [SLOT_W:0]  SLOT_LIMIT = (SLOT_W + 1)'(ENTRIES);

  state_t state_r, state_nxt;

  // Captured item.
  logic [VPN_BITS-1:0]   vpn_r;
  logic [VPN_BITS-1:0]   mask_r;
  logic [ASID_W-1:0]     asid_r;
  logic                  glob_r;
  logic [FRAME_BITS-1:0] fe_r;
  logic [FRAME_BITS-1:0] fo_r;
  logic                  ve_r;
  logic                  vo_r;
  logic [SLOT_W-1:0]     slot_r;

  // Scan sequencer.
  logic [IDX_W-1:0] iss_r, iss_nxt;
  logic             iss_done_r, iss_done_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;

  // Staged result.
  logic               res_status_r, res_status_nxt;
  logic               res_hit_r, res_hit_nxt;
  logic [MSLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [PFN_W-1:0]   res_fe_r, res_fe_nxt;
  logic [PFN_W-1:0]   res_fo_r, res_fo_nxt;
  logic               res_ve_r, res_ve_nxt;
  logic               res_vo_r, res_vo_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic               out_status_r, out_status_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic [MSLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [PFN_W-1:0]   out_fe_r, out_fe_nxt;
  logic [PFN_W-1:0]   out_fo_r, out_fo_nxt;
  logic               out_ve_r, out_ve_nxt;
  logic               out_vo_r, out_vo_nxt;

  st_ctl_t               st_ctl;
  logic [IDX_W-1:0]      rd_addr;
  logic                  rd_present;
  logic [VPN_BITS-1:0]   rd_vpn;
  logic [VPN_BITS-1:0]   rd_mask;
  logic [ASID_W-1:0]     rd_asid;
  logic                  rd_global;
  logic [FRAME_BITS-1:0] rd_fe;
  logic [FRAME_BITS-1:0] rd_fo;
  logic                  rd_ve;
  logic                  rd_vo;
  logic                  probe_hit;
  logic                  in_fire;
  logic                  slot_oor;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign slot_oor = ({1'b0, in_slot} >= SLOT_LIMIT);

  tepw_store #(
    .ENTRIES    (ENTRIES),
    .VPN_BITS   (VPN_BITS),
    .FRAME_BITS (FRAME_BITS),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (st_ctl),
    .wr_addr       (slot_r[IDX_W-1:0]),
    .wr_vpn        (vpn_r),
    .wr_mask       (mask_r),
    .wr_asid       (asid_r),
    .wr_global     (glob_r),
    .wr_frame_even (fe_r),
    .wr_frame_odd  (fo_r),
    .wr_valid_even (ve_r),
    .wr_valid_odd  (vo_r),
    .rd_addr       (rd_addr),
    .rd_present    (rd_present),
    .rd_vpn        (rd_vpn),
    .rd_mask       (rd_mask),
    .rd_asid       (rd_asid),
    .rd_global     (rd_global),
    .rd_frame_even (rd_fe),
    .rd_frame_odd  (rd_fo),
    .rd_valid_even (rd_ve),
    .rd_valid_odd  (rd_vo)
  );

  // One compare unit serves every entry of the scan.
  tepw_match #(
    .VPN_BITS (VPN_BITS)
  ) u_match (
    .probe_vpn  (vpn_r),
    .probe_asid (asid_r),
    .e_present  (rd_present),
    .e_vpn      (rd_vpn),
    .e_mask     (rd_mask),
    .e_asid     (rd_asid),
    .e_global   (rd_global),
    .hit        (probe_hit)
  );

  // Capture the item on accept; wide fields are cut to the stored widths.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      vpn_r  <= VPN_BITS'(in_virt_page);
      mask_r <= VPN_BITS'(in_page_mask);
      asid_r <= in_space_id;
      glob_r <= in_global_flag;
      fe_r   <= FRAME_BITS'(in_frame_even);
      fo_r   <= FRAME_BITS'(in_frame_odd);
      ve_r   <= in_valid_even;
      vo_r   <= in_valid_odd;
      slot_r <= in_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iss_r       <= '0;
      iss_done_r  <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      iss_done_r  <= iss_done_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    res_status_r <= res_status_nxt;
    res_hit_r    <= res_hit_nxt;
    res_slot_r   <= res_slot_nxt;
    res_fe_r     <= res_fe_nxt;
    res_fo_r     <= res_fo_nxt;
    res_ve_r     <= res_ve_nxt;
    res_vo_r     <= res_vo_nxt;
    out_status_r <= out_status_nxt;
    out_hit_r    <= out_hit_nxt;
    out_slot_r   <= out_slot_nxt;
    out_fe_r     <= out_fe_nxt;
    out_fo_r     <= out_fo_nxt;
    out_ve_r     <= out_ve_nxt;
    out_vo_r     <= out_vo_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    iss_nxt        = iss_r;
    iss_done_nxt   = iss_done_r;
    rd_vld_nxt     = rd_vld_r;
    rd_idx_nxt     = rd_idx_r;
    rd_addr        = iss_r;
    st_ctl         = '0;
    res_status_nxt = res_status_r;
    res_hit_nxt    = res_hit_r;
    res_slot_nxt   = res_slot_r;
    res_fe_nxt     = res_fe_r;
    res_fo_nxt     = res_fo_r;
    res_ve_nxt     = res_ve_r;
    res_vo_nxt     = res_vo_r;
    // Drop the output beat once taken.
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_hit_nxt    = out_hit_r;
    out_slot_nxt   = out_slot_r;
    out_fe_nxt     = out_fe_r;
    out_fo_nxt     = out_fo_r;
    out_ve_nxt     = out_ve_r;
    out_vo_nxt     = out_vo_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          // Every result field starts at zero.
          res_status_nxt = 1'b0;
          res_hit_nxt    = 1'b0;
          res_slot_nxt   = '0;
          res_fe_nxt     = '0;
          res_fo_nxt     = '0;
          res_ve_nxt     = 1'b0;
          res_vo_nxt     = 1'b0;
          unique case (op_t'(in_opcode))
            OP_PROBE: begin
              iss_nxt      = '0;
              iss_done_nxt = 1'b0;
              rd_vld_nxt   = 1'b0;
              state_nxt    = ST_SCAN;
            end
            OP_WRITE: begin
              res_status_nxt = slot_oor;
              state_nxt      = slot_oor ? ST_PUSH : ST_WRITE;
            end
            OP_READ: begin
              res_status_nxt = slot_oor;
              state_nxt      = slot_oor ? ST_PUSH : ST_FETCH;
            end
            OP_FLUSH: begin
              state_nxt = ST_FLUSH;
            end
            default: begin
              state_nxt = ST_PUSH;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Issue the next address while comparing the entry read last cycle.
        rd_addr    = iss_r;
        rd_vld_nxt = !iss_done_r;
        rd_idx_nxt = iss_r;
        if (!iss_done_r) begin
          iss_nxt      = iss_r + 1'b1;
          iss_done_nxt = (iss_r == LAST_IDX);
        end
        if (rd_vld_r) begin
          if (probe_hit) begin
            res_hit_nxt  = 1'b1;
            res_slot_nxt = MSLOT_W'(rd_idx_r);
            res_fe_nxt   = PFN_W'(rd_fe);
            res_fo_nxt   = PFN_W'(rd_fo);
            res_ve_nxt   = rd_ve;
            res_vo_nxt   = rd_vo;
            state_nxt    = ST_PUSH;
          end else if (rd_idx_r == LAST_IDX) begin
            state_nxt = ST_PUSH;
          end
        end
      end
      ST_FETCH: begin
        rd_addr   = slot_r[IDX_W-1:0];
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // An entry that is not present reads with zero frames and valid bits.
        res_slot_nxt = MSLOT_W'(slot_r);
        res_fe_nxt   = rd_present ? PFN_W'(rd_fe) : '0;
        res_fo_nxt   = rd_present ? PFN_W'(rd_fo) : '0;
        res_ve_nxt   = rd_present && rd_ve;
        res_vo_nxt   = rd_present && rd_vo;
        state_nxt    = ST_PUSH;
      end
      ST_WRITE: begin
        st_ctl.wr_en = 1'b1;
        state_nxt    = ST_PUSH;
      end
      ST_FLUSH: begin
        st_ctl.flush = 1'b1;
        state_nxt    = ST_PUSH;
      end
      ST_PUSH: begin
        // Hold the staged result until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_hit_nxt    = res_hit_r;
          out_slot_nxt   = res_slot_r;
          out_fe_nxt     = res_fe_r;
          out_fo_nxt     = res_fo_r;
          out_ve_nxt     = res_ve_r;
          out_vo_nxt     = res_vo_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_hit        = out_hit_r;
  assign out_match_slot = out_slot_r;
  assign out_frame_even = out_fe_r;
  assign out_frame_odd  = out_fo_r;
  assign out_valid_even = out_ve_r;
  assign out_valid_odd  = out_vo_r;

  `TEPW_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready,
    "input taken again right after an accept")
  `TEPW_ASSERT_SAME(a_hit_not_refused, out_valid && out_hit, !out_status,
    "hit reported together with an out-of-range status")
  `TEPW_ASSERT_SAME(a_refused_is_empty, out_valid && out_status,
    !out_hit && (out_match_slot == '0) && (out_frame_even == '0),
    "refused beat carries entry data")
  `TEPW_ASSERT_SAME(a_scan_trails_issue,
    (state_r == ST_SCAN) && rd_vld_r && !iss_done_r,
    iss_r == IDX_W'(rd_idx_r + 1'b1),
    "scan compare index out of step with issue index")

endmodule

/* tb/sv/tb_tlb_entry_probe_write_unit_pkg.sv */
// Beat types and the scoreboard that predicts translation buffer results.
package tb_tlb_entry_probe_write_unit_pkg;
  import tepw_pkg::*;

  localparam int TLB_DEPTH = 64;

  typedef struct packed {
    op_t                opcode;
    logic [VADDR_W-1:0] virt_page;
    logic [ASID_W-1:0]  space_id;
    logic [VADDR_W-1:0] page_mask;
    logic               global_flag;
    logic [PFN_W-1:0]   frame_even;
    logic [PFN_W-1:0]   frame_odd;
    logic               valid_even;
    logic               valid_odd;
    logic [SLOT_W-1:0]  slot;
  } tlb_beat_t;

  typedef struct packed {
    logic               status;
    logic               hit;
    logic [MSLOT_W-1:0] match_slot;
    logic [PFN_W-1:0]   frame_even;
    logic [PFN_W-1:0]   frame_odd;
    logic               valid_even;
    logic               valid_odd;
  } tlb_result_t;

  class tlb_scoreboard;
    // Shadow copy of the entry store.
    bit               present    [TLB_DEPTH];
    bit [VADDR_W-1:0] vpn        [TLB_DEPTH];
    bit [VADDR_W-1:0] mask       [TLB_DEPTH];
    bit [ASID_W-1:0]  asid       [TLB_DEPTH];
    bit               glob       [TLB_DEPTH];
    bit [PFN_W-1:0]   frame_even [TLB_DEPTH];
    bit [PFN_W-1:0]   frame_odd  [TLB_DEPTH];
    bit               valid_even [TLB_DEPTH];
    bit               valid_odd  [TLB_DEPTH];

    tlb_result_t expected_q[$];
    int fail_count;
    int checked;
    int probes, hits, writes, reads, flushes, refused;

    function int pending();
      return expected_q.size();
    endfunction

    function void clear_entries();
      for (int k = 0; k < TLB_DEPTH; k++) begin
        present[k]    = 1'b0;
        vpn[k]        = '0;
        mask[k]       = '0;
        asid[k]       = '0;
        glob[k]       = 1'b0;
        frame_even[k] = '0;
        frame_odd[k]  = '0;
        valid_even[k] = 1'b0;
        valid_odd[k]  = 1'b0;
      end
    endfunction

    function tlb_result_t entry_view(int k);
      tlb_result_t r;
      r            = '0;
      r.match_slot = MSLOT_W'(k);
      r.frame_even = frame_even[k];
      r.frame_odd  = frame_odd[k];
      r.valid_even = valid_even[k];
      r.valid_odd  = valid_odd[k];
      return r;
    endfunction

    function void note_input(tlb_beat_t b);
      tlb_result_t r;
      bit found;
      r     = '0;
      found = 1'b0;
      case (b.opcode)
        OP_PROBE: begin
          probes++;
          // Lowest present entry with a masked page match in this space wins.
          for (int k = 0; k < TLB_DEPTH; k++) begin
            if (!found && present[k] &&
                (((b.virt_page ^ vpn[k]) & ~mask[k]) == '0) &&
                (glob[k] || asid[k] == b.space_id)) begin
              r     = entry_view(k);
              r.hit = 1'b1;
              found = 1'b1;
            end
          end
          if (found) hits++;
        end
        OP_WRITE, OP_READ: begin
          if (b.slot >= TLB_DEPTH) begin
            r.status = 1'b1;
            refused++;
          end else if (b.opcode == OP_WRITE) begin
            writes++;
            present[b.slot]    = 1'b1;
            vpn[b.slot]        = b.virt_page;
            mask[b.slot]       = b.page_mask;
            asid[b.slot]       = b.space_id;
            glob[b.slot]       = b.global_flag;
            frame_even[b.slot] = b.frame_even;
            frame_odd[b.slot]  = b.frame_odd;
            valid_even[b.slot] = b.valid_even;
            valid_odd[b.slot]  = b.valid_odd;
          end else begin
            reads++;
            r = entry_view(int'(b.slot));
          end
        end
        default: begin
          flushes++;
          clear_entries();
        end
      endcase
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
      if (act_val !== exp_val) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
        fail_count++;
      end
    endfunction

    function void check_result(tlb_result_t got);
      tlb_result_t exp_r;
      checked++;
      if (expected_q.size() == 0) begin
        $error("result beat arrived with nothing outstanding");
        fail_count++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("status", exp_r.status, got.status);
      compare_field("hit", exp_r.hit, got.hit);
      compare_field("match_slot", exp_r.match_slot, got.match_slot);
      compare_field("out_frame_even", exp_r.frame_even, got.frame_even);
      compare_field("out_frame_odd", exp_r.frame_odd, got.frame_odd);
      compare_field("out_valid_even", exp_r.valid_even, got.valid_even);
      compare_field("out_valid_odd", exp_r.valid_odd, got.valid_odd);
    endfunction
  endclass

endpackage

/* tb/sv/tb_tlb_entry_probe_write_unit.sv */
// Top level testbench of the translation buffer: stimulus, result sink and watchdog.
module tb_tlb_entry_probe_write_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tepw_pkg::*;
  import tb_tlb_entry_probe_write_unit_pkg::*;

  localparam logic [VADDR_W-1:0] VPN_ONES = '1;
  localparam logic [PFN_W-1:0]   PFN_ONES = '1;
  localparam int RANDOM_BEATS = 930;
  // Long receiver hold-off: starts after this many results, lasts this many cycles.
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 400;

  // Drive every input to a known value from time zero.
  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic [OPCODE_W-1:0] in_opcode     = '0;
  logic [VADDR_W-1:0] in_virt_page   = '0;
  logic [ASID_W-1:0]  in_space_id    = '0;
  logic [VADDR_W-1:0] in_page_mask   = '0;
  logic               in_global_flag = 1'b0;
  logic [PFN_W-1:0]   in_frame_even  = '0;
  logic [PFN_W-1:0]   in_frame_odd   = '0;
  logic               in_valid_even  = 1'b0;
  logic               in_valid_odd   = 1'b0;
  logic [SLOT_W-1:0]  in_slot        = '0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic               out_status;
  logic               out_hit;
  logic [MSLOT_W-1:0] out_match_slot;
  logic [PFN_W-1:0]   out_frame_even;
  logic [PFN_W-1:0]   out_frame_odd;
  logic               out_valid_even;
  logic               out_valid_odd;

  tlb_scoreboard sb = new();

  tlb_entry_probe_write_unit #(.ENTRIES(TLB_DEPTH)) dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog: the slowest legal run is well under a millisecond.
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [VADDR_W-1:0] rand_page();
    return VADDR_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [PFN_W-1:0] rand_frame();
    return PFN_W'({$urandom(), $urandom()});
  endfunction

  // Favor narrow low masks, the shape that real page sizes take.
  function automatic logic [VADDR_W-1:0] rand_mask();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return '0;
    if (pick < 8) return (VADDR_W'(1) << $urandom_range(1, 24)) - 1;
    if (pick == 8) return VPN_ONES;
    return rand_page();
  endfunction

  function automatic tlb_beat_t make_beat(op_t op, logic [VADDR_W-1:0] vp,
                                          logic [ASID_W-1:0] sid, logic [VADDR_W-1:0] msk,
                                          logic g, logic [PFN_W-1:0] fe, logic [PFN_W-1:0] fo,
                                          logic ve, logic vo, logic [SLOT_W-1:0] sl);
    tlb_beat_t b;
    b.opcode      = op;
    b.virt_page   = vp;
    b.space_id    = sid;
    b.page_mask   = msk;
    b.global_flag = g;
    b.frame_even  = fe;
    b.frame_odd   = fo;
    b.valid_even  = ve;
    b.valid_odd   = vo;
    b.slot        = sl;
    return b;
  endfunction

  // Build one random beat. Most probes aim at a present entry so that hits,
  // near misses and priority between overlapping entries all show up.
  function automatic tlb_beat_t rand_beat();
    tlb_beat_t b;
    int sel;
    int k;
    sel = $urandom_range(0, 99);
    k   = $urandom_range(0, TLB_DEPTH - 1);
    b = make_beat(OP_PROBE, rand_page(), ASID_W'($urandom()), rand_mask(),
                  $urandom_range(0, 3) == 0, rand_frame(), rand_frame(),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), '0);
    b.slot = ($urandom_range(0, 99) < 85) ? SLOT_W'($urandom_range(0, TLB_DEPTH - 1))
                                          : SLOT_W'($urandom_range(TLB_DEPTH, 255));
    if (sel < 45) begin
      b.opcode = OP_PROBE;
      if ($urandom_range(0, 9) < 7 && sb.present[k]) begin
        // Land inside the entry's page; perturb only ignored bits.
        b.virt_page = sb.vpn[k] ^ (rand_page() & sb.mask[k]);
        if ($urandom_range(0, 9) < 7) b.space_id = sb.asid[k];
        // Flip one bit now and then for a near miss.
        if ($urandom_range(0, 9) == 0)
          b.virt_page = b.virt_page ^ (VADDR_W'(1) << $urandom_range(0, VADDR_W - 1));
      end
    end else if (sel < 75) begin
      b.opcode = OP_WRITE;
      // Shadow an existing page under another mask to exercise lowest-index priority.
      if ($urandom_range(0, 4) == 0 && sb.present[k]) begin
        b.virt_page = sb.vpn[k];
        b.space_id  = sb.asid[k];
      end
    end else if (sel < 99) begin
      b.opcode = OP_READ;
    end else begin
      b.opcode = OP_FLUSH;
    end
    return b;
  endfunction

  // Offer one beat after a random gap and hold it until accepted.
  task automatic send_beat(input tlb_beat_t b, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_opcode      <= b.opcode;
    in_virt_page   <= b.virt_page;
    in_space_id    <= b.space_id;
    in_page_mask   <= b.page_mask;
    in_global_flag <= b.global_flag;
    in_frame_even  <= b.frame_even;
    in_frame_odd   <= b.frame_odd;
    in_valid_even  <= b.valid_even;
    in_valid_odd   <= b.valid_odd;
    in_slot        <= b.slot;
    in_valid       <= 1'b1;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sb.note_input(b);
  endtask

  // Result sink: draw a stall per beat, take one beat, check it against the
  // oldest prediction. Once, hold off long enough to back up the input side.
  initial begin : result_sink
    int stall;
    tlb_result_t got;
    forever begin
      if (sb.checked == HOLD_AT)
        stall = HOLD_CYCLES;
      else if ((sb.checked / 50) % 5 == 2)
        stall = 0;
      else
        stall = $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      got.status     = out_status;
      got.hit        = out_hit;
      got.match_slot = out_match_slot;
      got.frame_even = out_frame_even;
      got.frame_odd  = out_frame_odd;
      got.valid_even = out_valid_even;
      got.valid_odd  = out_valid_odd;
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty-buffer miss, extremes, priority, masking,
    // refused slots, present-without-valid entries, flush.
    send_beat(make_beat(OP_PROBE, VPN_ONES, '0, '0, 0, '0, '0, 0, 0, '0), 0);
    send_beat(make_beat(OP_READ, '0, '0, '0, 0, '0, '0, 0, 0, 8'd5), 0);
    send_beat(make_beat(OP_WRITE, VPN_ONES, 8'hFF, '0, 1, PFN_ONES, '0, 1, 0, 8'd0), 0);
    // Present bit set even though both valid bits are clear.
    send_beat(make_beat(OP_WRITE, '0, 8'hAA, VPN_ONES, 0, '0, PFN_ONES, 0, 0, 8'd63), 0);
    send_beat(make_beat(OP_PROBE, VPN_ONES, 8'h00, '0, 0, '0, '0, 0, 0, '0), 0);
    send_beat(make_beat(OP_PROBE, '0, 8'hAA, '0, 0, '0, '0, 0, 0, '0), 0);
    send_beat(make_beat(OP_PROBE, 52'h123, 8'h55, '0, 0, '0, '0, 0, 0, '0), 0);
    send_beat(make_beat(OP_WRITE, VPN_ONES, 8'h01, '0, 0, 40'h12345, 40'hABCDE, 1, 1,
                        8'd1), 0);
    send_beat(make_beat(OP_PROBE, VPN_ONES, 8'h01, '0, 0, '0, '0, 0, 0, '0), 0);
    send_beat(make_beat(OP_WRITE, VPN_ONES, 8'hFF, VPN_ONES, 1, PFN_ONES, PFN_ONES, 1, 1,
                        8'd64), 0);
    send_beat(make_beat(OP_WRITE, VPN_ONES, 8'hFF, VPN_ONES, 1, PFN_ONES, PFN_ONES, 1, 1,
                        8'd255), 0);
    send_beat(make_beat(OP_READ, '0, '0, '0, 0, '0, '0, 0, 0, 8'd64), 0);
    send_beat(make_beat(OP_READ, '0, '0, '0, 0, '0, '0, 0, 0, 8'd255), 0);
    send_beat(make_beat(OP_READ, '0, '0, '0, 0, '0, '0, 0, 0, 8'd63), 0);
    send_beat(make_beat(OP_READ, '0, '0, '0, 0, '0, '0, 0, 0, 8'd0), 0);
    send_beat(make_beat(OP_WRITE, 52'hABC_DEF0_1234, 8'h3C, 52'hFFFF, 0, 40'h5A5A5,
                        40'hA5A5A, 1, 0, 8'd10), 0);
    send_beat(make_beat(OP_PROBE, 52'hABC_DEF0_FFFF, 8'h3C, '0, 0, '0, '0, 0, 0, '0), 0);
    send_beat(make_beat(OP_PROBE, 52'hABC_DEF1_1234, 8'h3C, '0, 0, '0, '0, 0, 0, '0), 0);
    send_beat(make_beat(OP_FLUSH, '0, '0, '0, 0, '0, '0, 0, 0, '0), 0);
    send_beat(make_beat(OP_PROBE, '0, 8'hAA, '0, 0, '0, '0, 0, 0, '0), 0);
    send_beat(make_beat(OP_READ, '0, '0, '0, 0, '0, '0, 0, 0, 8'd0), 0);
    send_beat(make_beat(OP_PROBE, VPN_ONES, 8'hFF, '0, 0, '0, '0, 0, 0, '0), 0);

    // Random part, with back-to-back beats in every fifth run of 50 beats.
    for (int n = 0; n < RANDOM_BEATS; n++)
      send_beat(rand_beat(), (n / 50) % 5 == 4);
    in_valid <= 1'b0;

    // Drain, then give a full scan's worth of cycles for stray beats.
    while (sb.pending() != 0) @(posedge clk);
    repeat (TLB_DEPTH + 16) @(posedge clk);

    $display("Covered %0d probes (%0d hits), %0d writes, %0d reads, %0d flushes,",
             sb.probes, sb.hits, sb.writes, sb.reads, sb.flushes);
    $display("%0d refused slot accesses, %0d result beats checked, %0d mismatches",
             sb.refused, sb.checked, sb.fail_count);
    if (sb.fail_count == 0 && sb.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
